// File: design/trrf_pkg.sv
// Package for the temporal rain-removal filter: sizes, widths and the
// control structs passed between the top level and the arithmetic unit.
// No dependencies.
package trrf_pkg;

    // History depth per sample position (power of two, the mean is a shift).
    localparam int HIST_DEPTH  = 8;
    localparam int HD_W        = $clog2(HIST_DEPTH);
    // Largest frame, in samples.
    localparam int MAX_SAMPLES = 16384;
    localparam int POS_W       = $clog2(MAX_SAMPLES);
    localparam int MEM_AW      = POS_W + HD_W;
    localparam int MEM_DEPTH   = MAX_SAMPLES * HIST_DEPTH;
    localparam int SAMP_W      = 8;
    localparam int CFG_W       = 15;
    localparam int FS_W        = $clog2(HIST_DEPTH + 1);
    // Sum of the history, and sum of absolute deviations.
    localparam int SUM_W       = $clog2(HIST_DEPTH * 255 + 1);
    // Weight (squared difference), weighted sum and weight sum.
    localparam int W_W         = 2 * SUM_W;
    localparam int NUM_W       = W_W + SAMP_W + HD_W;
    localparam int DEN_W       = W_W + HD_W;
    // Shared multiplier operands and product.
    localparam int MUL_A_W     = W_W;
    localparam int MUL_B_W     = SUM_W;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam logic [CFG_W-1:0] SPF_RESET = CFG_W'(MAX_SAMPLES);
    localparam logic [CFG_W-1:0] LEN_MAX   = CFG_W'(MAX_SAMPLES);

    // History values streamed from the top level into the arithmetic unit.
    typedef struct packed {
        logic              valid;
        logic [SAMP_W-1:0] value;
        logic [HD_W-1:0]   centre;
    } t_calc_in;

    // Result of the arithmetic unit, done is a one-cycle pulse.
    typedef struct packed {
        logic              done;
        logic [SAMP_W-1:0] result;
    } t_calc_out;

endpackage

// File: design/trrf_calc.sv
// Arithmetic unit of the rain-removal filter: collects the history of one
// position and works out the deviation-weighted average with one shared
// multiplier and a restoring divider. Depends on trrf_pkg.
module trrf_calc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trrf_pkg::t_calc_in  i_calc,
    output trrf_pkg::t_calc_out o_calc
);
    import trrf_pkg::*;

    localparam logic [2:0] P_LOAD = 3'd0;
    localparam logic [2:0] P_DEV  = 3'd1;
    localparam logic [2:0] P_SQ   = 3'd2;
    localparam logic [2:0] P_ACC  = 3'd3;
    localparam logic [2:0] P_DIV  = 3'd4;
    localparam logic [2:0] P_DONE = 3'd5;

    localparam logic [HD_W-1:0] CNT_LAST = HD_W'(HIST_DEPTH - 1);

    logic [2:0]         r_phase;
    logic [2:0]         n_phase;
    logic [HD_W-1:0]    r_cnt;
    logic [HD_W-1:0]    n_cnt;

    logic [SAMP_W-1:0]  r_h   [HIST_DEPTH];
    logic [SAMP_W-1:0]  r_dev [HIST_DEPTH];
    logic [SUM_W-1:0]   r_total;
    logic [SUM_W-1:0]   r_sdev;
    logic [SAMP_W-1:0]  r_cval;
    logic [W_W-1:0]     r_w;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_dsh;
    logic [SAMP_W-1:0]  r_q;
    logic [SAMP_W-1:0]  r_res;

    logic [SAMP_W-1:0]  mean;
    logic [SAMP_W-1:0]  dev;
    logic [SUM_W-1:0]   dw;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [NUM_W-1:0]   num_nx;
    logic [DEN_W-1:0]   den_nx;
    logic               rem_ge;
    logic               last;

    // Mean is a shift, the deviation of the value at the head of the line.
    assign mean = SAMP_W'(r_total >> HD_W);
    assign dev  = (r_h[0] >= mean) ? (r_h[0] - mean) : (mean - r_h[0]);
    assign dw   = r_sdev - SUM_W'(r_dev[0]);
    assign last = (r_cnt == CNT_LAST);

    // Shared multiplier: squares the difference, then scales the sample.
    always_comb begin
        if (r_phase == P_SQ) begin
            mul_a = MUL_A_W'(dw);
            mul_b = dw;
        end else begin
            mul_a = r_w;
            mul_b = MUL_B_W'(r_h[0]);
        end
        mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    assign num_nx = r_num + NUM_W'(mul_p);
    assign den_nx = r_den + DEN_W'(r_w);
    assign rem_ge = (r_rem >= r_dsh);

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        unique case (r_phase)
            P_LOAD: begin
                if (i_calc.valid) begin
                    n_cnt = r_cnt + 1'b1;
                    if (last) begin
                        n_phase = P_DEV;
                    end
                end
            end
            P_DEV: begin
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_phase = P_SQ;
                end
            end
            P_SQ: begin
                if (r_sdev == '0) begin
                    n_phase = P_DONE;
                end else begin
                    n_phase = P_ACC;
                end
            end
            P_ACC: begin
                n_cnt   = r_cnt + 1'b1;
                n_phase = last ? P_DIV : P_SQ;
            end
            P_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (last) begin
                    n_phase = P_DONE;
                end
            end
            P_DONE: begin
                n_phase = P_LOAD;
                n_cnt   = '0;
            end
            default: begin
                n_phase = P_LOAD;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_LOAD;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath: shift lines for history and deviations, accumulators, divider.
    always_ff @(posedge i_clk) begin
        case (r_phase)
            P_LOAD: begin
                if (i_calc.valid) begin
                    for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                        r_h[i] <= r_h[i+1];
                    end
                    r_h[HIST_DEPTH-1] <= i_calc.value;
                    r_total <= (r_cnt == '0) ? SUM_W'(i_calc.value)
                                             : r_total + SUM_W'(i_calc.value);
                    if (r_cnt == i_calc.centre) begin
                        r_cval <= i_calc.value;
                    end
                end
            end
            P_DEV: begin
                for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                    r_h[i]   <= r_h[i+1];
                    r_dev[i] <= r_dev[i+1];
                end
                r_h[HIST_DEPTH-1]   <= r_h[0];
                r_dev[HIST_DEPTH-1] <= dev;
                r_sdev <= (r_cnt == '0) ? SUM_W'(dev) : r_sdev + SUM_W'(dev);
            end
            P_SQ: begin
                r_w   <= W_W'(mul_p);
                r_res <= r_cval;
            end
            P_ACC: begin
                for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                    r_h[i]   <= r_h[i+1];
                    r_dev[i] <= r_dev[i+1];
                end
                r_h[HIST_DEPTH-1]   <= r_h[0];
                r_dev[HIST_DEPTH-1] <= r_dev[0];
                r_num <= (r_cnt == '0) ? NUM_W'(mul_p) : num_nx;
                r_den <= (r_cnt == '0) ? DEN_W'(r_w) : den_nx;
                if (last) begin
                    r_rem <= num_nx;
                    r_dsh <= NUM_W'(den_nx) << (SAMP_W - 1);
                end
            end
            P_DIV: begin
                // One quotient bit per cycle, most significant first.
                if (rem_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= {r_q[SAMP_W-2:0], rem_ge};
                if (last) begin
                    r_res <= {r_q[SAMP_W-2:0], rem_ge};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_calc.done   = (r_phase == P_DONE);
    assign o_calc.result = r_res;

endmodule

// File: design/temporal_rain_removal_filter_core.sv
// Top level of the temporal rain-removal filter: handshakes, frame and
// warm-up bookkeeping, and the history memory. Depends on trrf_pkg and
// trrf_calc.

// The block keeps the last eight values of every sample position in a
// 128K x 8 memory with one write and one registered read per cycle. During
// warm-up an item is stored and returned unchanged. After warm-up an item's
// history is first read from the memory, then the arithmetic unit works out
// the deviations, then the weights (its one multiplier forms each weight as a
// square, then scales the sample by it), then runs the bit-serial divide and
// hands the result back. When the whole history is flat the weights and the
// divide are skipped. The result waits in an output register, so the block
// goes on with the next item while it is held. The history memory is not
// cleared after reset; warm-up writes every entry of the positions that its
// frames reach before any of them is read.
module temporal_rain_removal_filter_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [trrf_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [trrf_pkg::SAMP_W-1:0]  i_sample,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [trrf_pkg::SAMP_W-1:0]  o_filtered,
    output logic                         o_frame_done
);
    import trrf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [FS_W-1:0] FS_FULL  = FS_W'(HIST_DEPTH);
    localparam logic [HD_W-1:0] IDX_LAST = HD_W'(HIST_DEPTH - 1);
    localparam logic [HD_W-1:0] HALF     = HD_W'(HIST_DEPTH / 2);

    logic [1:0]         r_state;
    logic [CFG_W-1:0]   r_spf;
    logic [FS_W-1:0]    r_frames;
    logic [HD_W-1:0]    r_centre;
    logic [POS_W-1:0]   r_position;
    logic [HD_W-1:0]    r_rd_idx;
    logic               r_rd_vld;
    logic               r_wr_pend;
    logic               r_done;
    logic               r_out_valid;
    logic [SAMP_W-1:0]  r_sample;
    logic [SAMP_W-1:0]  r_result;
    logic [SAMP_W-1:0]  r_filtered;
    logic               r_frame_done;
    logic [SAMP_W-1:0]  r_mem [MEM_DEPTH];
    logic [SAMP_W-1:0]  r_rd_data;

    logic               accept;
    logic               warm;
    logic               ld;
    logic [CFG_W-1:0]   len;
    logic               done;
    logic [HD_W-1:0]    oldest;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [SAMP_W-1:0]  mem_wdata;
    logic [MEM_AW-1:0]  mem_raddr;
    t_calc_in           calc_in;
    t_calc_out          calc_out;

    // Input handshake and warm-up status.
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign warm    = (r_frames < FS_FULL);
    assign oldest  = r_centre - HALF;

    // Effective frame length: zero acts as one, large values are capped.
    always_comb begin
        if (r_spf == '0) begin
            len = CFG_W'(1);
        end else if (r_spf > LEN_MAX) begin
            len = LEN_MAX;
        end else begin
            len = r_spf;
        end
    end
    assign done = ((CFG_W'(r_position) + CFG_W'(1)) >= len);

    // The result moves to the output register once that register is free.
    assign ld = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spf <= SPF_RESET;
        end else if (i_cfg_we) begin
            r_spf <= i_cfg_wdata;
        end
    end

    // Sequencer and frame bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frames    <= '0;
            r_centre    <= HALF;
            r_position  <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_READ);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rd_idx <= '0;
                        if (warm) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state   <= S_READ;
                            r_wr_pend <= 1'b1;
                        end
                    end
                end
                S_READ: begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                    if (r_rd_idx == IDX_LAST) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_wr_pend <= 1'b0;
                    if (calc_out.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (ld) begin
                        r_state    <= S_IDLE;
                        r_position <= r_done ? '0 : r_position + 1'b1;
                        if (r_done) begin
                            if (warm) begin
                                r_frames <= r_frames + 1'b1;
                            end else begin
                                r_centre <= r_centre + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Output valid.
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
            r_done   <= done;
            r_result <= i_sample;
        end
        if ((r_state == S_CALC) && calc_out.done) begin
            r_result <= calc_out.result;
        end
        if (ld) begin
            r_filtered   <= r_result;
            r_frame_done <= r_done;
        end
    end

    // History memory: warm-up stores on accept, later the oldest slot is
    // overwritten once the whole history has been read.
    assign mem_we    = (accept && warm) || ((r_state == S_CALC) && r_wr_pend);
    assign mem_waddr = (r_state == S_IDLE) ? {r_position, r_frames[HD_W-1:0]}
                                           : {r_position, oldest};
    assign mem_wdata = (r_state == S_IDLE) ? i_sample : r_sample;
    assign mem_raddr = {r_position, r_rd_idx};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // Arithmetic unit.
    assign calc_in.valid  = r_rd_vld;
    assign calc_in.value  = r_rd_data;
    assign calc_in.centre = r_centre;

    trrf_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_calc  (calc_in),
        .o_calc  (calc_out)
    );

    assign o_valid      = r_out_valid;
    assign o_filtered   = r_filtered;
    assign o_frame_done = r_frame_done;

`ifndef NO_ASSERTIONS
    // The arithmetic unit only finishes while the sequencer waits for it.
    a_calc_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        calc_out.done |-> (r_state == S_CALC))
        else $error("arithmetic unit finished outside the calc state");

    // Warm-up count only ever steps by one and never passes the depth.
    a_frames_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_frames) |-> (r_frames == $past(r_frames) + 1'b1)
                               && (r_frames <= FS_FULL))
        else $error("warm-up frame count moved wrongly");

    // The centre slot moves only after warm-up has completed.
    a_centre_after_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_centre) |-> ($past(r_frames) == FS_FULL))
        else $error("centre slot moved during warm-up");

    // The last item of a frame sends the position back to the start.
    a_position_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && r_done) |=> (r_position == '0))
        else $error("position did not wrap at end of frame");
`endif

endmodule

// File: verif/trrf_checker.sv
// Checker for the temporal rain-removal filter: watches the sample and result
// channels, predicts each filtered item and compares it with the block's output.
// Depends on trrf_pkg for sizes and widths.
`timescale 1ns / 1ps

module trrf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [trrf_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [trrf_pkg::SAMP_W-1:0] i_sample,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [trrf_pkg::SAMP_W-1:0] i_filtered,
    input  logic                        i_frame_done,
    output int                          o_pending,
    output int                          o_fail_count
);

    import trrf_pkg::*;

    typedef struct packed {
        logic [SAMP_W-1:0] filtered;
        logic              frame_done;
    } t_filter_result;

    // Expected results in order, and the predictor's copy of the block state.
    t_filter_result    expected_q[$];
    t_filter_result    oldest;
    logic [SAMP_W-1:0] history_mem [MAX_SAMPLES][HIST_DEPTH];
    logic [CFG_W-1:0]  frame_cfg;
    int unsigned       warm_frames;
    int unsigned       centre;
    int unsigned       position;
    int                fail_total = 0;

    assign o_fail_count = fail_total;

    // Effective frame length: zero acts as one, oversize is clamped.
    function automatic int unsigned frame_length();
        int unsigned len;
        len = 32'(frame_cfg);
        if (len == 0) len = 1;
        if (len > MAX_SAMPLES) len = MAX_SAMPLES;
        return len;
    endfunction

    // Weighted temporal average of one position's history.
    function automatic logic [SAMP_W-1:0] weigh_history(input int unsigned pos);
        int unsigned     total;
        int unsigned     mean;
        int unsigned     sdev;
        int unsigned     dev [HIST_DEPTH];
        longint unsigned num;
        longint unsigned den;
        longint unsigned w;
        longint unsigned quot;
        total = 0;
        for (int i = 0; i < HIST_DEPTH; i++) total += history_mem[pos][i];
        mean = total / HIST_DEPTH;
        sdev = 0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            if (history_mem[pos][i] >= mean) dev[i] = history_mem[pos][i] - mean;
            else dev[i] = mean - history_mem[pos][i];
            sdev += dev[i];
        end
        // A flat history returns the centre slot as it is.
        if (sdev == 0) return history_mem[pos][centre % HIST_DEPTH];
        num = 0;
        den = 0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            w = longint'(sdev - dev[i]);
            w = w * w;
            num += w * history_mem[pos][i];
            den += w;
        end
        if (den == 0) return history_mem[pos][centre % HIST_DEPTH];
        quot = num / den;
        return (quot > 255) ? 8'hFF : quot[SAMP_W-1:0];
    endfunction

    // Advance the predicted state by one accepted sample.
    function automatic t_filter_result step_filter(input logic [SAMP_W-1:0] s);
        t_filter_result r;
        int unsigned    len;
        int unsigned    pos;
        int unsigned    slot;
        logic           done;
        len = frame_length();
        pos = position;
        if (pos >= MAX_SAMPLES) pos = MAX_SAMPLES - 1;
        done = (pos + 1 >= len);
        if (warm_frames < HIST_DEPTH) begin
            // Warm-up stores the frame in its own slot and passes it through.
            history_mem[pos][warm_frames] = s;
            r.filtered = s;
            if (done) warm_frames++;
        end else begin
            slot = (centre + HIST_DEPTH - HIST_DEPTH / 2) % HIST_DEPTH;
            r.filtered = weigh_history(pos);
            history_mem[pos][slot] = s;
            if (done) centre = (centre + 1) % HIST_DEPTH;
        end
        position = done ? 0 : pos + 1;
        r.frame_done = done;
        return r;
    endfunction

    // Results are checked before the new item is predicted, since an item
    // never comes out on the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            frame_cfg   = SPF_RESET;
            warm_frames = 0;
            centre      = HIST_DEPTH / 2;
            position    = 0;
        end else begin
            if (i_cfg_we) frame_cfg = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result with no item outstanding: filtered %0d, frame_done %0d",
                           i_filtered, i_frame_done);
                    fail_total++;
                end else begin
                    oldest = expected_q.pop_front();
                    if (i_filtered !== oldest.filtered) begin
                        $error("filtered mismatch: expected %0d, actual %0d",
                               oldest.filtered, i_filtered);
                        fail_total++;
                    end
                    if (i_frame_done !== oldest.frame_done) begin
                        $error("frame_done mismatch: expected %0d, actual %0d",
                               oldest.frame_done, i_frame_done);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_q.push_back(step_filter(i_sample));
        end
        o_pending <= expected_q.size();
    end

endmodule

// File: verif/testbench.sv
// Top of the temporal rain-removal filter testbench: clock, reset, stimulus,
// watchdog and verdict. Depends on trrf_pkg, trrf_checker and the filter core.
`timescale 1ns / 1ps

module testbench;

    import trrf_pkg::*;

    localparam int WARM_LEN       = 16;
    localparam int ITEM_TARGET    = 1750;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    logic [SAMP_W-1:0] sample;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [SAMP_W-1:0] filtered;
    logic              frame_done;
    int                pending;
    int                fail_count;

    // Stimulus bookkeeping: scene level per position and where the frame is.
    logic              steady = 1'b0;
    logic [SAMP_W-1:0] scene_base [WARM_LEN];
    int unsigned       scene_pos = 0;
    int unsigned       scene_len = MAX_SAMPLES;
    int                sent_items = 0;
    int                idle_cycles = 0;
    int                phase;
    int                pick;
    int                count;

    temporal_rain_removal_filter_core uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_sample     (sample),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_filtered   (filtered),
        .o_frame_done (frame_done)
    );

    trrf_checker filter_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_sample     (sample),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_filtered   (filtered),
        .i_frame_done (frame_done),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #1 clk = ~clk;

    // The receiver stalls at random except during the steady stretch.
    always @(posedge clk) begin
        out_stall <= !steady && ($urandom_range(0, 99) < 31);
    end

    // End the run if nothing moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // A scene level: the extremes often, otherwise anything.
    function automatic logic [SAMP_W-1:0] pick_level();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return SAMP_W'($urandom_range(0, 255));
    endfunction

    // Mostly a still scene, with rain streaks and small jitter on top.
    function automatic logic [SAMP_W-1:0] scene_sample(input int unsigned pos);
        int unsigned r;
        int          v;
        if ($urandom_range(0, 99) < 2) scene_base[pos] = pick_level();
        r = $urandom_range(0, 99);
        if (r < 80) return scene_base[pos];
        if (r < 90) return SAMP_W'($urandom_range(0, 255));
        v = int'(scene_base[pos]) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[SAMP_W-1:0];
    endfunction

    // Warm-up frames: a few positions get fixed histories, the rest the scene.
    function automatic logic [SAMP_W-1:0] warm_sample(input int unsigned pos,
                                                      input int unsigned frame);
        case (pos)
            0: return 8'h00;
            1: return 8'hFF;
            2: return frame[0] ? 8'hFF : 8'h00;
            3: return (frame == 5) ? 8'hFF : 8'd128;
            default: return scene_sample(pos);
        endcase
    endfunction

    // Present one item, idling first at random, and wait until it is taken.
    task automatic push_sample(input logic [SAMP_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_items++;
        scene_pos = (scene_pos + 1 >= scene_len) ? 0 : scene_pos + 1;
    endtask

    // Hold off the sender until every outstanding item has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Frame length is only changed with the block idle.
    task automatic set_frame_length(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (value == 0) scene_len = 1;
        else if (value > LEN_MAX) scene_len = MAX_SAMPLES;
        else scene_len = 32'(value);
    endtask

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        sample    <= '0;
        for (int p = 0; p < WARM_LEN; p++) scene_base[p] = pick_level();
        scene_base[0] = 8'h00;
        scene_base[1] = 8'hFF;
        scene_base[2] = 8'h00;
        scene_base[3] = 8'd128;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Warm-up at the longest frame run to its end, so every later position is filled.
        set_frame_length(CFG_W'(WARM_LEN));
        for (int f = 0; f < HIST_DEPTH; f++) begin
            for (int p = 0; p < WARM_LEN; p++) push_sample(warm_sample(p, f));
        end

        // First filtered frame carries the sample extremes.
        for (int p = 0; p < WARM_LEN; p++) push_sample(p[0] ? 8'hFF : 8'h00);

        // Random phases, each under its own frame length.
        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            steady = (phase == 5 || phase == 6);
            pick   = $urandom_range(0, 9);
            count  = $urandom_range(20, 160);
            if (pick == 0) begin
                // Oversize frame entered at position zero and left mid-frame
                // before any unfilled position is reached.
                set_frame_length(CFG_W'(1));
                push_sample(scene_sample(scene_pos));
                set_frame_length($urandom_range(0, 1) ? CFG_W'(LEN_MAX) : {CFG_W{1'b1}});
                count = $urandom_range(1, WARM_LEN - 1);
            end else if (pick == 1) begin
                set_frame_length('0);
                count = $urandom_range(10, 40);
            end else if (pick == 2) begin
                set_frame_length(CFG_W'(WARM_LEN));
            end else begin
                set_frame_length(CFG_W'($urandom_range(1, WARM_LEN)));
            end
            for (int i = 0; i < count; i++) begin
                if (phase % 3 == 1 && i == count / 2) drain_results();
                push_sample(scene_sample(scene_pos));
            end
            phase++;
        end
        steady = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
design/trrf_pkg.sv
design/trrf_calc.sv
design/temporal_rain_removal_filter_core.sv
verif/trrf_checker.sv
verif/testbench.sv
